>>> hw/rtl/fcva_pkg.sv
`timescale 1ns / 1ps
package fcva_pkg;

   // Internal datapath widths: normalized magnitudes sit below 2^30
   // and grow by the rotation gain, so 34 signed bits hold x and y.
   localparam int CORE_W = 34;
   // Accumulated angle in turns * 2^32, signed with headroom.
   localparam int ZW = 33;
   // Normalization brings the larger magnitude to at least 2^29.
   localparam int NORM_LIMIT = 30;

   localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
   localparam logic [ZW-1:0] QUARTER_TURN = ZW'(33'h0_4000_0000);

   // atan(2^-i) in turns * 2^32
   localparam logic [31:0] ATAN_TURNS [0:31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   // Quadrant code. On an axis it also gives the angle in quarter turns.
   typedef enum logic [1:0] {
      QUAD_FIRST  = 2'd0,
      QUAD_SECOND = 2'd1,
      QUAD_THIRD  = 2'd2,
      QUAD_FOURTH = 2'd3
   } quad_type;

   // Word passed from cell to cell along the chain
   typedef struct packed {
      logic signed [CORE_W-1:0] x;
      logic signed [CORE_W-1:0] y;
      logic signed [ZW-1:0]     z;
      logic                     axis;
      quad_type                 quad;
   } vec_type;

   // Radian code of one full turn, the wrap point of the output
   function automatic logic [31:0] full_angle(input int frac_bits);
      logic [63:0] sum;
      int          sh;
      sh  = 61 - frac_bits;
      sum = ({32'd0, TWO_PI_Q29} << 32) + (64'd1 << (sh - 1));
      return 32'(sum >> sh);
   endfunction

endpackage

>>> hw/rtl/fcva_norm_cell.sv
`timescale 1ns / 1ps
module fcva_norm_cell
   import fcva_pkg::*;
#(
   parameter int SHIFT = 1
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  vec_type in_word,
   output logic    out_valid,
   input  logic    out_ready,
   output vec_type out_word
);

   logic              valid_ff;
   vec_type           word_ff;
   vec_type           word_in;
   logic [CORE_W-1:0] mag_or;
   logic              fits;

   // shift both magnitudes by SHIFT if the larger one stays below 2^30
   assign mag_or = in_word.x | in_word.y;
   assign fits   = (mag_or >> (NORM_LIMIT - SHIFT)) == '0;

   always_comb begin
      word_in = in_word;
      if (fits) begin
         word_in.x = in_word.x <<< SHIFT;
         word_in.y = in_word.y <<< SHIFT;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> hw/rtl/fcva_rot_cell.sv
`timescale 1ns / 1ps
module fcva_rot_cell
   import fcva_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  vec_type in_word,
   output logic    out_valid,
   input  logic    out_ready,
   output vec_type out_word
);

   localparam logic signed [CORE_W-1:0] STEP_MASK =
      CORE_W'((64'd1 << STEP) - 64'd1);
   localparam logic signed [ZW-1:0] STEP_ANGLE =
      ZW'({1'b0, ATAN_TURNS[5'(STEP)]});

   logic                     valid_ff;
   vec_type                  word_ff;
   vec_type                  word_in;
   logic signed [CORE_W-1:0] bias_x;
   logic signed [CORE_W-1:0] bias_y;
   logic signed [CORE_W-1:0] dx;
   logic signed [CORE_W-1:0] dy;

   // shift right rounding toward zero: bias negative values first
   assign bias_x = in_word.x[CORE_W-1] ? STEP_MASK : '0;
   assign bias_y = in_word.y[CORE_W-1] ? STEP_MASK : '0;
   assign dx     = (in_word.y + bias_y) >>> STEP;
   assign dy     = (in_word.x + bias_x) >>> STEP;

   // micro-rotation toward y = 0
   always_comb begin
      word_in = in_word;
      if (!in_word.y[CORE_W-1]) begin
         word_in.x = in_word.x + dx;
         word_in.y = in_word.y - dy;
         word_in.z = in_word.z + STEP_ANGLE;
      end else begin
         word_in.x = in_word.x - dx;
         word_in.y = in_word.y + dy;
         word_in.z = in_word.z - STEP_ANGLE;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> hw/rtl/fcva_fold.sv
`timescale 1ns / 1ps
module fcva_fold
   import fcva_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 13
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  vec_type                    in_word,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [ANGLE_FRAC_BITS+2:0] out_angle
);

   localparam int AW = ANGLE_FRAC_BITS + 3;
   localparam int SH = 61 - ANGLE_FRAC_BITS;
   localparam logic [63:0]   ROUND_ADD = 64'd1 << (SH - 1);
   localparam logic [AW-1:0] FULL_ANG  = AW'(full_angle(ANGLE_FRAC_BITS));

   logic          v1_ff, v2_ff, v3_ff, v4_ff;
   logic          r1, r2, r3, r4;
   logic [31:0]   t_ff;
   logic          wrap1_ff, wrap2_ff, wrap3_ff;
   logic [63:0]   prod_ff;
   logic [AW-1:0] ang_ff;
   logic [AW-1:0] angle_ff;

   logic [ZW-1:0] th;
   logic [32:0]   t_in;
   logic [63:0]   prod_in;
   logic [63:0]   sum;
   logic [AW-1:0] ang_in;
   logic [AW-1:0] angle_in;

   // stage ready chain
   assign r4       = !v4_ff || out_ready;
   assign r3       = !v3_ff || r4;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
      end
   end

   // clamp first-quadrant angle to 0 .. quarter turn, fold by quadrant
   always_comb begin
      if (in_word.z[ZW-1]) begin
         th = '0;
      end else if (in_word.z > $signed(QUARTER_TURN)) begin
         th = QUARTER_TURN;
      end else begin
         th = in_word.z;
      end
      if (in_word.axis) begin
         t_in = {1'b0, in_word.quad, 30'd0};
      end else begin
         unique case (in_word.quad)
            QUAD_FIRST:  t_in = th;
            QUAD_SECOND: t_in = 33'h0_8000_0000 - th;
            QUAD_THIRD:  t_in = 33'h0_8000_0000 + th;
            QUAD_FOURTH: t_in = 33'h1_0000_0000 - th;
            default:     t_in = th;
         endcase
      end
   end

   // turns to radians
   assign prod_in = t_ff * TWO_PI_Q29;
   assign sum     = prod_ff + ROUND_ADD;
   assign ang_in  = AW'(sum >> SH);

   // full turn and anything that rounds to it wrap to zero
   assign angle_in = (wrap3_ff || ang_ff >= FULL_ANG) ? '0 : ang_ff;

   always_ff @(posedge clock) begin
      if (r1 && in_valid) begin
         t_ff     <= t_in[31:0];
         wrap1_ff <= t_in[32];
      end
      if (r2 && v1_ff) begin
         prod_ff  <= prod_in;
         wrap2_ff <= wrap1_ff;
      end
      if (r3 && v2_ff) begin
         ang_ff   <= ang_in;
         wrap3_ff <= wrap2_ff;
      end
      if (r4 && v3_ff) begin
         angle_ff <= angle_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_angle = angle_ff;

endmodule

>>> hw/rtl/full_circle_vector_angle_top.sv
`timescale 1ns / 1ps
// Full-circle vector angle.
// Input channel req_: one word per vector, signed x and y coordinates.
// Result channel rsp_: angle in radians, unsigned Q3.ANGLE_FRAC_BITS,
// from 0 up to but excluding 2 pi; a value that rounds to 2 pi gives 0.
// Axis vectors give 0, pi/2, pi, 3pi/2 exactly; the origin gives 0.
// The datapath is a chain of registered cells: an input register that
// takes magnitudes and quadrant, five normalization shift cells
// (16, 8, 4, 2, 1), one micro-rotation cell per step, then fold,
// multiply, round and output register stages.
// One word enters per cycle while the receiver keeps taking results;
// this rate is set by the one-cell-per-step chain.
// Every cell has its own valid and local ready, so a stalled receiver
// holds the result in the output register while earlier cells keep
// filling bubbles; req_ready drops only when the whole chain is full.
// Reset empties all cells; no state survives between words.
module full_circle_vector_angle_top
   import fcva_pkg::*;
#(
   parameter int COORD_WIDTH     = 16,
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int ROTATION_STEPS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_y_coord,
   input  logic signed [COORD_WIDTH-1:0] req_x_coord,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ANGLE_FRAC_BITS+2:0]    rsp_angle
);

   localparam int AW    = ANGLE_FRAC_BITS + 3;
   localparam int NORMS = 5;
   localparam int NODES = NORMS + ROTATION_STEPS + 1;
   localparam logic [AW-1:0] FULL_ANG = AW'(full_angle(ANGLE_FRAC_BITS));

   logic                   valid_ff;
   vec_type                word_ff;
   vec_type                word_in;
   logic [COORD_WIDTH-1:0] x_mag;
   logic [COORD_WIDTH-1:0] y_mag;
   logic                   x_neg, y_neg, x_zero, y_zero;

   logic    node_valid [0:NODES-1];
   logic    node_ready [0:NODES-1];
   vec_type node_word  [0:NODES-1];

   // magnitudes and quadrant of the incoming vector
   assign x_neg  = req_x_coord[COORD_WIDTH-1];
   assign y_neg  = req_y_coord[COORD_WIDTH-1];
   assign x_zero = req_x_coord == '0;
   assign y_zero = req_y_coord == '0;
   assign x_mag  = x_neg ? (~req_x_coord + 1'b1) : req_x_coord;
   assign y_mag  = y_neg ? (~req_y_coord + 1'b1) : req_y_coord;

   always_comb begin
      word_in.x    = $signed({{(CORE_W-COORD_WIDTH){1'b0}}, x_mag});
      word_in.y    = $signed({{(CORE_W-COORD_WIDTH){1'b0}}, y_mag});
      word_in.z    = '0;
      word_in.axis = x_zero || y_zero;
      priority if (x_zero && y_zero) begin
         word_in.quad = QUAD_FIRST;
      end else if (x_zero) begin
         word_in.quad = y_neg ? QUAD_FOURTH : QUAD_SECOND;
      end else if (y_zero) begin
         word_in.quad = x_neg ? QUAD_THIRD : QUAD_FIRST;
      end else if (!x_neg && !y_neg) begin
         word_in.quad = QUAD_FIRST;
      end else if (x_neg && !y_neg) begin
         word_in.quad = QUAD_SECOND;
      end else if (x_neg) begin
         word_in.quad = QUAD_THIRD;
      end else begin
         word_in.quad = QUAD_FOURTH;
      end
   end

   // input register
   assign req_ready = !valid_ff || node_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         word_ff <= word_in;
      end
   end

   assign node_valid[0] = valid_ff;
   assign node_word[0]  = word_ff;

   // normalization cells
   for (genvar k = 0; k < NORMS; k++) begin : g_norm
      fcva_norm_cell #(
         .SHIFT (16 >> k)
      ) u_norm (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (node_valid[k]),
         .in_ready  (node_ready[k]),
         .in_word   (node_word[k]),
         .out_valid (node_valid[k+1]),
         .out_ready (node_ready[k+1]),
         .out_word  (node_word[k+1])
      );
   end

   // micro-rotation cells
   for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_rot
      fcva_rot_cell #(
         .STEP (i)
      ) u_rot (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (node_valid[NORMS+i]),
         .in_ready  (node_ready[NORMS+i]),
         .in_word   (node_word[NORMS+i]),
         .out_valid (node_valid[NORMS+i+1]),
         .out_ready (node_ready[NORMS+i+1]),
         .out_word  (node_word[NORMS+i+1])
      );
   end

   // fold, scale to radians, output register
   fcva_fold #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_fold (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (node_valid[NODES-1]),
      .in_ready  (node_ready[NODES-1]),
      .in_word   (node_word[NODES-1]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_angle (rsp_angle)
   );

   // checks
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle < FULL_ANG)
      else $error("angle at or above full turn");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output register");

   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word present right after reset");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;

   localparam int CW = 16;
   localparam int AW = 16;
   localparam int DIRECTED_ROWS = 23;
   localparam int RANDOM_VECTORS = 1730;
   localparam int HOLD_START = 300;
   localparam int HOLD_VECTORS = 80;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES = 40;

   // Exact axis codes, Q3.13 radians rounded to nearest
   localparam logic [AW-1:0] ANG_ZERO = 16'd0;
   localparam logic [AW-1:0] ANG_HALF_PI = 16'd12868;
   localparam logic [AW-1:0] ANG_PI = 16'd25736;
   localparam logic [AW-1:0] ANG_THREE_HALF_PI = 16'd38604;

   // Angle arithmetic in turns * 2^32
   localparam longint NORM_FLOOR = 64'h2000_0000;
   localparam longint QTURN = 64'h4000_0000;
   localparam longint unsigned RAD_Q29 = 64'd3373259426;
   localparam int RAD_SHIFT = 48;

   // atan(2^-i) in turns * 2^32, one entry per micro-rotation
   localparam logic [31:0] MICRO_TURNS [0:15] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
   };

   localparam logic signed [CW-1:0] EDGE_VALS [0:5] = '{-32768, -32767, -1, 0, 1, 32767};

   typedef struct packed {
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] x;
      logic                 pinned;
      logic [AW-1:0]        angle;
   } vector_row_type;

   // Directed vectors: origin, axes, corners, most negative values, near-axis
   // wrap and overshoot cases, unit diagonals
   localparam vector_row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      '{0, 0, 1'b1, ANG_ZERO},
      '{0, 1, 1'b1, ANG_ZERO},
      '{0, 32767, 1'b1, ANG_ZERO},
      '{1, 0, 1'b1, ANG_HALF_PI},
      '{32767, 0, 1'b1, ANG_HALF_PI},
      '{0, -1, 1'b1, ANG_PI},
      '{0, -32768, 1'b1, ANG_PI},
      '{-1, 0, 1'b1, ANG_THREE_HALF_PI},
      '{-32768, 0, 1'b1, ANG_THREE_HALF_PI},
      '{32767, 32767, 1'b0, ANG_ZERO},
      '{-32768, -32768, 1'b0, ANG_ZERO},
      '{32767, -32768, 1'b0, ANG_ZERO},
      '{-32768, 32767, 1'b0, ANG_ZERO},
      '{-1, 32767, 1'b0, ANG_ZERO},
      '{1, 32767, 1'b0, ANG_ZERO},
      '{32767, 1, 1'b0, ANG_ZERO},
      '{-32768, 1, 1'b0, ANG_ZERO},
      '{1, -32768, 1'b0, ANG_ZERO},
      '{-1, -32768, 1'b0, ANG_ZERO},
      '{1, 1, 1'b0, ANG_ZERO},
      '{-1, -1, 1'b0, ANG_ZERO},
      '{1, -1, 1'b0, ANG_ZERO},
      '{-1, 1, 1'b0, ANG_ZERO}
   };

   typedef struct {
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] x;
      logic [AW-1:0]        angle;
   } pending_angle_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [CW-1:0] req_y_coord;
   logic signed [CW-1:0] req_x_coord;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [AW-1:0]        rsp_angle;

   // Typed-in expectation riding along with the current word
   logic                 row_pinned;
   logic [AW-1:0]        row_angle;

   pending_angle_type angle_q[$];
   int                mismatches = 0;
   int                angles_checked = 0;
   int                input_stalls = 0;
   int                req_gap_max = 12;
   int                rsp_stall_max = 12;
   bit                hold_output = 1'b0;

   full_circle_vector_angle_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_y_coord (req_y_coord),
      .req_x_coord (req_x_coord),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_angle   (rsp_angle)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("%0t: timeout, %0d angles still outstanding", $time, angle_q.size());
      $display("TEST FAILED");
      $finish;
   end

   // Shift right toward zero, also for negative values
   function automatic longint shift_toward_zero(input longint v, input int s);
      if (v >= 0)
         return v >>> s;
      return -((-v) >>> s);
   endfunction

   // Turns * 2^32 to Q3.13 radians, rounded half up
   function automatic longint unsigned turns_to_code(input longint unsigned turns);
      return (turns * RAD_Q29 + (64'd1 << (RAD_SHIFT - 1))) >> RAD_SHIFT;
   endfunction

   // Polar angle of (x, y) folded into 0 .. 2 pi
   function automatic logic [AW-1:0] predict_angle(input logic signed [CW-1:0] y_in,
                                                   input logic signed [CW-1:0] x_in);
      longint          y;
      longint          x;
      longint          cx;
      longint          cy;
      longint          z;
      longint          dx;
      longint          dy;
      longint          turns;
      longint unsigned uturns;
      longint unsigned code;
      int              i;
      y = y_in;
      x = x_in;
      if (x == 0) begin
         turns = (y > 0) ? QTURN : (y < 0) ? 3 * QTURN : 0;
      end else if (y == 0) begin
         turns = (x > 0) ? 0 : 2 * QTURN;
      end else begin
         cx = (x < 0) ? -x : x;
         cy = (y < 0) ? -y : y;
         z = 0;
         // normalize, then CORDIC vectoring drives y toward zero
         while (cx < NORM_FLOOR && cy < NORM_FLOOR) begin
            cx = cx <<< 1;
            cy = cy <<< 1;
         end
         for (i = 0; i < 16; i++) begin
            dx = shift_toward_zero(cy, i);
            dy = shift_toward_zero(cx, i);
            if (cy >= 0) begin
               cx = cx + dx;
               cy = cy - dy;
               z = z + longint'(MICRO_TURNS[i]);
            end else begin
               cx = cx - dx;
               cy = cy + dy;
               z = z - longint'(MICRO_TURNS[i]);
            end
         end
         if (z < 0)
            z = 0;
         if (z > QTURN)
            z = QTURN;
         // fold by quadrant
         if (x > 0 && y > 0)
            turns = z;
         else if (x < 0 && y > 0)
            turns = 2 * QTURN - z;
         else if (x < 0)
            turns = 2 * QTURN + z;
         else
            turns = 4 * QTURN - z;
      end
      uturns = turns;
      code = turns_to_code(uturns);
      // a code that rounds to 2 pi wraps to 0
      if (code >= turns_to_code(64'd1 << 32))
         code = 0;
      return code[AW-1:0];
   endfunction

   // Random vector: mostly full range, plus small, near-axis, corner and diagonal ones
   function automatic void draw_vector(output logic signed [CW-1:0] y,
                                       output logic signed [CW-1:0] x);
      int kind;
      kind = $urandom_range(0, 99);
      y = 16'($urandom());
      x = 16'($urandom());
      if (kind < 15) begin
         y = 16'($urandom_range(0, 16)) - 16'd8;
         x = 16'($urandom_range(0, 16)) - 16'd8;
      end else if (kind < 30) begin
         if ($urandom_range(0, 1))
            y = 16'($urandom_range(0, 4)) - 16'd2;
         else
            x = 16'($urandom_range(0, 4)) - 16'd2;
      end else if (kind < 40) begin
         y = EDGE_VALS[$urandom_range(0, 5)];
         x = EDGE_VALS[$urandom_range(0, 5)];
      end else if (kind < 50) begin
         y = x + (16'($urandom_range(0, 6)) - 16'd3);
         if ($urandom_range(0, 1))
            y = -y;
      end
   endfunction

   // Offer one word after an idle gap; returns at the falling edge after acceptance
   task automatic send_vector(input logic signed [CW-1:0] y, input logic signed [CW-1:0] x,
                              input logic pinned, input logic [AW-1:0] angle, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_y_coord <= y;
      req_x_coord <= x;
      row_pinned <= pinned;
      row_angle <= angle;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stop offering until every expected angle has come back
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (angle_q.size() != 0);
   endtask

   // Scoreboard: check the result word, then record the accepted input word
   always @(posedge clock) begin
      pending_angle_type head;
      pending_angle_type entry;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (angle_q.size() == 0) begin
               $display("%0t: unexpected angle word: expected none, actual %0d",
                        $time, rsp_angle);
               mismatches++;
            end else begin
               head = angle_q.pop_front();
               angles_checked++;
               if (rsp_angle !== head.angle) begin
                  $display("%0t: angle mismatch for y=%0d x=%0d: expected %0d, actual %0d",
                           $time, head.y, head.x, head.angle, rsp_angle);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_ready)
            input_stalls++;
         if (req_valid && req_ready) begin
            entry.y = req_y_coord;
            entry.x = req_x_coord;
            entry.angle = row_pinned ? row_angle : predict_angle(req_y_coord, req_x_coord);
            angle_q.push_back(entry);
         end
      end
   end

   // Result side: random stall before each word, one long hold-off on request
   initial begin
      int stall;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_output) begin
            hold_output = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Input side and run control
   initial begin
      logic signed [CW-1:0] vy;
      logic signed [CW-1:0] vx;
      int                   gap;
      int                   n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_y_coord = '0;
      req_x_coord = '0;
      row_pinned = 1'b0;
      row_angle = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (n = 0; n < DIRECTED_ROWS; n++)
         send_vector(DIRECTED[n].y, DIRECTED[n].x, DIRECTED[n].pinned, DIRECTED[n].angle,
                     $urandom_range(0, 12));

      // random part in phases: both sides idling, none, and mostly sender idling
      for (n = 0; n < RANDOM_VECTORS; n++) begin
         if (n % 125 == 0) begin
            case ((n / 125) % 3)
               0: begin
                  req_gap_max = 12;
                  rsp_stall_max = 12;
               end
               1: begin
                  req_gap_max = 0;
                  rsp_stall_max = 0;
               end
               default: begin
                  req_gap_max = 12;
                  rsp_stall_max = 2;
               end
            endcase
         end
         if (n == HOLD_START)
            hold_output = 1'b1;
         if (n == 900 || n == 1400)
            pause_until_drained();
         draw_vector(vy, vx);
         gap = (n >= HOLD_START && n < HOLD_START + HOLD_VECTORS) ? 0
               : $urandom_range(0, req_gap_max);
         send_vector(vy, vx, 1'b0, ANG_ZERO, gap);
      end
      req_valid <= 1'b0;

      // drain, then watch for stray words
      while (angle_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d angle words from %0d directed and %0d random vectors;",
               angles_checked, DIRECTED_ROWS, RANDOM_VECTORS);
      $display("input backpressure seen on %0d cycles, %0d mismatches.",
               input_stalls, mismatches);
      if (mismatches == 0 && angle_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> full_circle_vector_angle_top.f
hw/rtl/fcva_pkg.sv
hw/rtl/fcva_norm_cell.sv
hw/rtl/fcva_rot_cell.sv
hw/rtl/fcva_fold.sv
hw/rtl/full_circle_vector_angle_top.sv
tb/sv/tb.sv
